>>> design/lidar_point_azimuth_time_interp_top_assert.svh
// assertion macros for the lidar point decoder port checker
`ifndef LIDAR_POINT_AZIMUTH_TIME_INTERP_TOP_ASSERT_SVH
`define LIDAR_POINT_AZIMUTH_TIME_INTERP_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LPAT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpat: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LPAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpat: next-cycle check failed");

`endif

>>> design/lpat_pkg.sv
// shared types and constants for the lidar point decoder
`default_nettype none

package lpat_pkg;

    // field widths
    localparam int BLK_W   = 4;
    localparam int SLOT_W  = 5;
    localparam int AZ_W    = 16;
    localparam int DIST_W  = 16;
    localparam int REFL_W  = 8;
    localparam int STAMP_W = 32;
    localparam int K_W     = 6;
    localparam int CHAN_W  = 4;
    localparam int AZF_W   = 21;
    localparam int DMM_W   = 17;
    localparam int TNS_W   = 42;
    localparam int PROD_W  = 22;
    localparam int SUM_W   = 23;
    localparam int TOFF_W  = 21;

    // bus widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 96;

    // fixed point constants
    localparam logic [SLOT_W-1:0] HALF_SLOTS     = 5'd16;
    localparam logic [K_W-1:0]    SLOT_SKIP      = 6'd8;
    localparam logic [K_W-1:0]    FINE_PER_CDEG  = 6'd48;
    localparam logic [AZ_W-1:0]   FULL_TURN_CDEG = 16'd36000;
    localparam logic [SUM_W-1:0]  FULL_TURN_FINE = 23'd1728000;
    localparam logic [9:0]        NS_PER_US      = 10'd1000;
    localparam logic [11:0]       SLOT_NS        = 12'd2304;
    localparam logic [16:0]       BLOCK_NS       = 17'd110592;

    // raw input item
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [REFL_W-1:0]  refl;
        logic [DIST_W-1:0]  dist_raw;
        logic               next_present;
        logic [AZ_W-1:0]    nxt;
        logic [AZ_W-1:0]    cur;
        logic [SLOT_W-1:0]  slot;
        logic [BLK_W-1:0]   blk;
    } t_in_item;

    // item after gap resolution
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [REFL_W-1:0]  refl;
        logic [DIST_W-1:0]  dist_raw;
        logic [AZ_W-1:0]    gap;
        logic [AZ_W-1:0]    cur;
        logic [CHAN_W-1:0]  chan;
        logic [K_W-1:0]     k;
        logic [BLK_W-1:0]   blk;
    } t_front_item;

    // item after the product stage
    typedef struct packed {
        logic [TNS_W-1:0]  t_base;
        logic [TOFF_W-1:0] t_offs;
        logic [PROD_W-1:0] az_base;
        logic [PROD_W-1:0] az_step;
        logic [DMM_W-1:0]  dist_mm;
        logic [REFL_W-1:0] refl;
        logic [CHAN_W-1:0] chan;
    } t_prod_item;

    // finished result
    typedef struct packed {
        logic [TNS_W-1:0]  time_ns;
        logic [CHAN_W-1:0] chan;
        logic [REFL_W-1:0] refl;
        logic [DMM_W-1:0]  dist_mm;
        logic [AZF_W-1:0]  az_fine;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/lidar_point_azimuth_time_interp_top.sv
// top level of the lidar point decoder
//
//   channel   direction  signals                         carries
//   s_axis    in         tvalid tready tdata tuser       one raw return per transfer
//   m_axis    out        tvalid tready tdata             one decoded point per transfer
//
// one transfer per cycle in and out when neither side stalls
// the path has three registered stages: input register, product register, result register
// each stage holds its item until the next takes it; ready passes back in the same cycle
// the input stalls only while all three stages are full and the result is not taken
// reset clears the stage valid flags and the held azimuth gap
`default_nettype none

module lidar_point_azimuth_time_interp_top
    import lpat_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // block_number, firing_slot, block_azimuth, next_azimuth, distance_raw,
    // return_strength, stamp_us, zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // next_present
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // azimuth_fine, distance_mm, reflect_out, laser_channel, point_time_ns, zero fill
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    t_in_item    in_item;
    t_front_item front_item;
    t_prod_item  prod_item;
    t_out_item   out_item;
    logic        front_valid;
    logic        mul_ready;
    logic        mul_valid;
    logic        out_ready;

    // unpack the input transfer
    always_comb begin
        in_item.blk          = s_axis_tdata[3:0];
        in_item.slot         = s_axis_tdata[8:4];
        in_item.cur          = s_axis_tdata[24:9];
        in_item.nxt          = s_axis_tdata[40:25];
        in_item.dist_raw     = s_axis_tdata[56:41];
        in_item.refl         = s_axis_tdata[64:57];
        in_item.stamp        = s_axis_tdata[96:65];
        in_item.next_present = s_axis_tuser;
    end

    lpat_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (front_valid),
        .i_ready (mul_ready),
        .o_item  (front_item)
    );

    lpat_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (mul_ready),
        .i_item  (front_item),
        .o_valid (mul_valid),
        .i_ready (out_ready),
        .o_item  (prod_item)
    );

    lpat_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (out_ready),
        .i_item  (prod_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (out_item)
    );

    // pack the output transfer
    assign m_axis_tdata = {4'b0, out_item.time_ns, out_item.chan, out_item.refl,
                           out_item.dist_mm, out_item.az_fine};

endmodule

`default_nettype wire

>>> design/lpat_front.sv
// input register stage with azimuth gap tracking and slot decode
`default_nettype none

module lpat_front
    import lpat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_front_item      o_item
);

    logic        r_valid;
    t_in_item    r_in;
    logic [AZ_W-1:0] r_held_gap;
    logic [AZ_W-1:0] n_fresh_gap;
    logic [AZ_W-1:0] n_gap;
    logic [K_W-1:0]  n_k;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // valid flag and held gap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_held_gap <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (r_valid && i_ready) begin
                r_held_gap <= n_gap;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
    end

    // gap to next block, rollover adds a full turn, kept modulo 2^16
    always_comb begin
        n_fresh_gap = r_in.nxt - r_in.cur;
        if (r_in.nxt < r_in.cur) begin
            n_fresh_gap = n_fresh_gap + FULL_TURN_CDEG;
        end
        n_gap = r_in.next_present ? n_fresh_gap : r_held_gap;
    end

    // firing index: second sequence skips eight slot times
    always_comb begin
        if (r_in.slot < HALF_SLOTS) begin
            n_k = K_W'(r_in.slot);
        end else begin
            n_k = K_W'(r_in.slot) + SLOT_SKIP;
        end
    end

    always_comb begin
        o_item.stamp    = r_in.stamp;
        o_item.refl     = r_in.refl;
        o_item.dist_raw = r_in.dist_raw;
        o_item.gap      = n_gap;
        o_item.cur      = r_in.cur;
        o_item.chan     = r_in.slot[CHAN_W-1:0];
        o_item.k        = n_k;
        o_item.blk      = r_in.blk;
    end

endmodule

`default_nettype wire

>>> design/lpat_mul.sv
// product stage: azimuth terms and time terms
`default_nettype none

module lpat_mul
    import lpat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_front_item i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_prod_item       o_item
);

    logic       r_valid;
    t_prod_item r_prod;
    t_prod_item n_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_prod;

    // products, one multiply per term but two for the time offset
    always_comb begin
        n_prod.az_base = PROD_W'(i_item.cur) * PROD_W'(FINE_PER_CDEG);
        n_prod.az_step = PROD_W'(i_item.gap) * PROD_W'(i_item.k);
        n_prod.t_base  = TNS_W'(i_item.stamp) * TNS_W'(NS_PER_US);
        n_prod.t_offs  = TOFF_W'(i_item.blk) * TOFF_W'(BLOCK_NS)
                       + TOFF_W'(i_item.k) * TOFF_W'(SLOT_NS);
        n_prod.dist_mm = {i_item.dist_raw, 1'b0};
        n_prod.refl    = i_item.refl;
        n_prod.chan    = i_item.chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod <= n_prod;
        end
    end

endmodule

`default_nettype wire

>>> design/lpat_out.sv
// sum stage: azimuth wrap at a full turn, time sum, result register
`default_nettype none

module lpat_out
    import lpat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_prod_item i_item,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_item
);

    logic             r_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] n_wrap;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_out;

    // sum stays below four turns, so pick one of four offsets
    always_comb begin
        n_sum = SUM_W'(i_item.az_base) + SUM_W'(i_item.az_step);
        if (n_sum >= SUM_W'(3) * FULL_TURN_FINE) begin
            n_wrap = n_sum - SUM_W'(3) * FULL_TURN_FINE;
        end else if (n_sum >= SUM_W'(2) * FULL_TURN_FINE) begin
            n_wrap = n_sum - SUM_W'(2) * FULL_TURN_FINE;
        end else if (n_sum >= FULL_TURN_FINE) begin
            n_wrap = n_sum - FULL_TURN_FINE;
        end else begin
            n_wrap = n_sum;
        end
        n_out.az_fine = n_wrap[AZF_W-1:0];
        n_out.dist_mm = i_item.dist_mm;
        n_out.refl    = i_item.refl;
        n_out.chan    = i_item.chan;
        n_out.time_ns = i_item.t_base + TNS_W'(i_item.t_offs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> design/lpat_checker.sv
// port-level checks for the lidar point decoder, bound to the top level
`default_nettype none

`include "lidar_point_azimuth_time_interp_top_assert.svh"

module lpat_checker
    import lpat_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [AZF_W-1:0] az_fine;

    assign az_fine = m_axis_tdata[AZF_W-1:0];

    // wrapped azimuth stays inside one turn
    `LPAT_ASSERT_SAME(a_az_in_turn, m_axis_tvalid, 23'(az_fine) < FULL_TURN_FINE)
    // distance in mm is even and fill bits are zero
    `LPAT_ASSERT_SAME(a_dist_fill, m_axis_tvalid, !m_axis_tdata[21] && m_axis_tdata[95:92] == 4'b0)
    // input only backs up while a result is held and not taken
    `LPAT_ASSERT_SAME(a_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // a stalled result stays put
    `LPAT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind lidar_point_azimuth_time_interp_top lpat_checker u_lpat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> sim/lpat_point_checker.sv
// scoreboard for the lidar point decoder: predicts each point and compares the stream output
module lpat_point_checker
    import lpat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int unsigned TURN_CDEG   = 36000;
    localparam longint unsigned TURN_FINE = 64'd1728000;
    localparam int unsigned FINE_SCALE  = 48;
    localparam int unsigned NS_SLOT     = 2304;
    localparam int unsigned NS_BLOCK    = 110592;

    typedef struct packed {
        logic [41:0] time_ns;
        logic [3:0]  chan;
        logic [7:0]  refl;
        logic [16:0] dist_mm;
        logic [20:0] az_fine;
    } point_t;

    point_t      expected_points[$];
    logic [15:0] last_gap;
    int          fail_total;

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        last_gap     = '0;
    end

    // decode one raw return into the point it should produce, using the given gap
    function automatic point_t decode_return(input logic [S_TDATA_W-1:0] raw,
                                             input logic [15:0] gap);
        point_t          pt;
        logic [3:0]      blk;
        logic [4:0]      slot;
        logic [15:0]     cur;
        logic [5:0]      k;
        longint unsigned az;
        longint unsigned tns;
        blk  = raw[3:0];
        slot = raw[8:4];
        cur  = raw[24:9];
        k    = (slot < 5'd16) ? {1'b0, slot} : 6'(slot) + 6'd8;
        az   = (longint'(cur) * FINE_SCALE + longint'(gap) * k) % TURN_FINE;
        tns  = longint'(raw[96:65]) * 1000 + longint'(blk) * NS_BLOCK
             + longint'(k) * NS_SLOT;
        pt.az_fine = az[20:0];
        pt.dist_mm = {raw[56:41], 1'b0};
        pt.refl    = raw[64:57];
        pt.chan    = slot[3:0];
        pt.time_ns = tns[41:0];
        return pt;
    endfunction

    function automatic int field_bad(input string name, input longint unsigned exp_val,
                                     input longint unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        logic [15:0]  cur;
        logic [15:0]  nxt;
        int unsigned  top;
        point_t       want;
        point_t       got;
        int           bad;
        if (!i_rst_n) begin
            last_gap = '0;
            expected_points.delete();
        end else begin
            // input transfer: update the held gap, then queue the prediction
            if (s_axis_tvalid && s_axis_tready) begin
                cur = s_axis_tdata[24:9];
                nxt = s_axis_tdata[40:25];
                if (s_axis_tuser) begin
                    top      = nxt + ((nxt < cur) ? TURN_CDEG : 0);
                    last_gap = 16'(top - cur);
                end
                expected_points.push_back(decode_return(s_axis_tdata, last_gap));
            end
            // output transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[91:0];
                if (expected_points.size() == 0) begin
                    $error("point transfer with no prediction pending: %h", got);
                    fail_total++;
                end else begin
                    want = expected_points.pop_front();
                    bad  = field_bad("azimuth_fine", want.az_fine, got.az_fine)
                         + field_bad("distance_mm", want.dist_mm, got.dist_mm)
                         + field_bad("reflect_out", want.refl, got.refl)
                         + field_bad("laser_channel", want.chan, got.chan)
                         + field_bad("point_time_ns", want.time_ns, got.time_ns);
                    fail_total += bad;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_points.size();
    end

endmodule

>>> sim/tb_top.sv
// testbench top for the lidar point decoder: stimulus, stalls and verdict
module tb_top;
    import lpat_pkg::*;

    localparam int TARGET_RETURNS = 1650;
    localparam int CYCLE_LIMIT    = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // block_number, firing_slot, block_azimuth, next_azimuth, distance_raw,
    // return_strength, stamp_us, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // next_present
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // azimuth_fine, distance_mm, reflect_out, laser_channel, point_time_ns, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_points;
    int cycle_count = 0;
    int returns_sent = 0;
    bit no_gaps = 1'b0;

    lidar_point_azimuth_time_interp_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lpat_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_points)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle counter and timeout
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // idle length before the next input transfer: mostly short, a few long
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one raw return and hold it until the block takes it
    task automatic send_return(input logic [3:0] blk, input logic [4:0] slot,
                               input logic [15:0] cur, input logic [15:0] nxt,
                               input logic np, input logic [15:0] dist_raw,
                               input logic [7:0] refl, input logic [31:0] stamp);
        int idle;
        idle = no_gaps ? 0 : next_gap();
        if (idle > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tdata  = {7'd0, stamp, refl, dist_raw, nxt, cur, slot, blk};
        s_axis_tuser  = np;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        returns_sent++;
    endtask

    // one well-formed packet: 12 blocks with azimuth advancing by a common step, last block has no next
    task automatic send_packet();
        logic [31:0] stamp;
        int          base;
        int          step;
        int          cur;
        int          nxt;
        int          n;
        bit          full;
        stamp   = $urandom;
        base    = $urandom_range(0, 35999);
        step    = ($urandom_range(0, 99) < 80) ? $urandom_range(15, 45)
                                               : $urandom_range(0, 400);
        no_gaps = ($urandom_range(0, 3) == 0);
        full    = ($urandom_range(0, 9) == 0);
        for (int b = 0; b < 12; b++) begin
            cur = (base + b * step) % 36000;
            nxt = (base + (b + 1) * step) % 36000;
            n   = full ? 32 : $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                send_return(4'(b), full ? 5'(i) : 5'($urandom_range(0, 31)),
                            16'(cur), 16'(nxt), (b < 11), 16'($urandom),
                            8'($urandom), stamp);
        end
    endtask

    // arbitrary return: any block number, azimuths sometimes out of range
    task automatic send_noise();
        logic [15:0] cur;
        logic [15:0] nxt;
        cur = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
        nxt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
        send_return(4'($urandom), 5'($urandom), cur, nxt, 1'($urandom),
                    16'($urandom), 8'($urandom), $urandom);
    endtask

    // result side back-pressure
    initial begin
        int hold;
        int r;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_axis_tready = 1'b1;
                    hold = $urandom_range(0, 3);
                end else if (r < 85) begin
                    m_axis_tready = 1'b0;
                    hold = $urandom_range(0, 2);
                end else if (r < 95) begin
                    m_axis_tready = 1'b1;
                    hold = $urandom_range(20, 120);
                end else begin
                    m_axis_tready = 1'b0;
                    hold = $urandom_range(8, 30);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // last block before any gap seen: held gap is zero
        send_return(4'd0, 5'd31, 16'd35999, 16'd0, 1'b0, 16'd0, 8'd0, 32'd0);
        // plain gap, first and last slot of the first firing sequence, first slot of the second
        send_return(4'd0, 5'd0, 16'd100, 16'd200, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFFFFFF);
        send_return(4'd1, 5'd15, 16'd100, 16'd200, 1'b1, 16'd1, 8'd1, 32'd1);
        send_return(4'd1, 5'd16, 16'd100, 16'd200, 1'b1, 16'd2, 8'd2, 32'd1000);
        // held gap reused by the last block
        send_return(4'd11, 5'd31, 16'd300, 16'd0, 1'b0, 16'h8000, 8'h80, 32'h80000000);
        // rollover across 360 degrees and azimuth wrap
        send_return(4'd10, 5'd31, 16'd35900, 16'd100, 1'b1, 16'h5555, 8'h55, 32'h55555555);
        send_return(4'd11, 5'd24, 16'd35999, 16'd0, 1'b1, 16'hAAAA, 8'hAA, 32'hAAAAAAAA);
        send_return(4'd11, 5'd31, 16'd35999, 16'd0, 1'b0, 16'h1234, 8'h12, 32'hFFFFFFFF);
        // zero gap
        send_return(4'd2, 5'd7, 16'd0, 16'd0, 1'b1, 16'd7, 8'd7, 32'd7);
        // azimuths out of range
        send_return(4'd3, 5'd31, 16'hFFFF, 16'd0, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFFFFFF);
        send_return(4'd4, 5'd31, 16'd0, 16'hFFFF, 1'b1, 16'd0, 8'd0, 32'd0);
        send_return(4'd5, 5'd16, 16'hFFFF, 16'hFFFF, 1'b1, 16'd3, 8'd3, 32'd3);
        send_return(4'd6, 5'd30, 16'd40000, 16'd35999, 1'b0, 16'd4, 8'd4, 32'd4);
        // block numbers beyond the packet
        send_return(4'd12, 5'd1, 16'd18000, 16'd18040, 1'b1, 16'd5, 8'd5, 32'hFFFFFFFF);
        send_return(4'd15, 5'd31, 16'd18000, 16'd18040, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFFFFFF);
        send_return(4'd15, 5'd31, 16'd18000, 16'd0, 1'b0, 16'd6, 8'd6, 32'd6);

        // random part: mostly well-formed packets, some noise bursts
        while (returns_sent < TARGET_RETURNS) begin
            if ($urandom_range(0, 99) < 15) begin
                no_gaps = 1'b0;
                repeat ($urandom_range(1, 8)) send_noise();
            end else begin
                send_packet();
            end
        end
        s_axis_tvalid = 1'b0;

        // drain
        while (pending_points != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/lpat_pkg.sv
design/lpat_front.sv
design/lpat_mul.sv
design/lpat_out.sv
design/lidar_point_azimuth_time_interp_top.sv
design/lpat_checker.sv
sim/lpat_point_checker.sv
sim/tb_top.sv
